// ===== hw/rtl/msgcm_pkg.sv =====
package msgcm_pkg;

    localparam int STOP_SLOTS_DEF = 4;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int POS_W   = 17;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int STOP_W  = POS_W + COLOR_W;
    localparam int COUNT_W = 3;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int QUEUE_DEPTH = 2;

    // register indexes on the config port
    localparam int CFG_STOP_COUNT = 0;
    localparam int CFG_STOP_BASE  = 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET    = 3'd2;
    localparam logic [STOP_W-1:0]  STOP_RESET_ONE = {17'h10000, 24'hFFFFFF};
    localparam logic [STOP_W-1:0]  STOP_RESET_ANY = '0;
    localparam logic [COLOR_W-1:0] COLOR_WHITE    = 24'hFFFFFF;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_MIX,
        BK_HOLD
    } back_state_t;

    // one classified request between front and back
    typedef struct packed {
        logic               interp;
        logic [COLOR_W-1:0] color_a;
        logic [COLOR_W-1:0] color_b;
        logic [POS_W-1:0]   num;
        logic [POS_W-1:0]   span;
    } msgcm_item_t;

endpackage

// ===== hw/rtl/multi_stop_gradient_color_map.sv =====
// channel   dir  handshake                  payload
// config    in   cfg_we                     cfg_index, cfg_wdata (stop_count, stop_0..)
// density   in   s_tvalid / s_tready        s_tdata[16:0] density
// color     out  m_tvalid / m_tready        m_tdata[23:0] red, green, blue
//
// a density outside the gradient, on a zero-width segment or with no match
// goes straight to the output register; an interpolated one first passes
// the restoring divider, which produces one fraction bit per cycle, and then the mixer
// aresetn (synchronous, active low) loads the default stops and empties the queue
// a two-entry queue takes up to two densities while the result side is stalled
module multi_stop_gradient_color_map
    import msgcm_pkg::*;
#(
    parameter int STOP_SLOTS = STOP_SLOTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [$clog2(STOP_SLOTS+1)-1:0] cfg_index,
    input  logic [STOP_W-1:0]               cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_TDATA_W-1:0]           s_tdata,  // [16:0] density
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_TDATA_W-1:0]          m_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

    logic        push_valid, push_ready;
    msgcm_item_t push_item;
    logic        pop_valid, pop_ready;
    msgcm_item_t pop_item;

    msgcm_front #(
        .STOP_SLOTS (STOP_SLOTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .density    (s_tdata[POS_W-1:0]),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    msgcm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    msgcm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== hw/rtl/msgcm_front.sv =====
module msgcm_front
    import msgcm_pkg::*;
#(
    parameter int STOP_SLOTS = STOP_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [$clog2(STOP_SLOTS+1)-1:0]   cfg_index,
    input  logic [STOP_W-1:0]                 cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [POS_W-1:0]                  density,
    input  logic                              push_ready,
    output logic                              push_valid,
    output msgcm_item_t                       push_item
);

    localparam int IDX_W  = $clog2(STOP_SLOTS + 1);
    localparam int SLOT_W = $clog2(STOP_SLOTS);

    logic [COUNT_W-1:0] count_reg;
    logic [STOP_W-1:0]  stop_reg [STOP_SLOTS];

    logic [POS_W-1:0]   pos   [STOP_SLOTS];
    logic [COLOR_W-1:0] color [STOP_SLOTS];

    logic [COUNT_W-1:0] n_used;
    logic [COUNT_W-1:0] last_cnt;
    logic [SLOT_W-1:0]  last_slot;

    logic               seg_found;
    logic [POS_W-1:0]   seg_p0;
    logic [POS_W-1:0]   seg_p1;
    logic [COLOR_W-1:0] seg_ca;
    logic [COLOR_W-1:0] seg_cb;
    logic [POS_W-1:0]   seg_span;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
            for (int i = 0; i < STOP_SLOTS; i++) begin
                stop_reg[i] <= (i == 1) ? STOP_RESET_ONE : STOP_RESET_ANY;
            end
        end else if (cfg_we) begin
            if (cfg_index == IDX_W'(CFG_STOP_COUNT)) begin
                count_reg <= cfg_wdata[COUNT_W-1:0];
            end
            for (int i = 0; i < STOP_SLOTS; i++) begin
                if (cfg_index == IDX_W'(CFG_STOP_BASE + i)) begin
                    stop_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < STOP_SLOTS; i++) begin
            pos[i]   = stop_reg[i][STOP_W-1:COLOR_W];
            color[i] = stop_reg[i][COLOR_W-1:0];
        end
    end

    // clamp the stop count into 1..STOP_SLOTS
    always_comb begin
        if (count_reg == '0) begin
            n_used = COUNT_W'(1);
        end else if (count_reg > COUNT_W'(STOP_SLOTS)) begin
            n_used = COUNT_W'(STOP_SLOTS);
        end else begin
            n_used = count_reg;
        end
        last_cnt  = n_used - COUNT_W'(1);
        last_slot = last_cnt[SLOT_W-1:0];
    end

    // lowest matching segment wins, so scan from the top down
    always_comb begin
        seg_found = 1'b0;
        seg_p0    = pos[0];
        seg_p1    = pos[0];
        seg_ca    = color[0];
        seg_cb    = color[0];
        for (int i = STOP_SLOTS - 2; i >= 0; i--) begin
            if ((COUNT_W'(i) < last_cnt) && (pos[i] <= density) && (density <= pos[i+1])) begin
                seg_found = 1'b1;
                seg_p0    = pos[i];
                seg_p1    = pos[i+1];
                seg_ca    = color[i];
                seg_cb    = color[i+1];
            end
        end
        seg_span = seg_p1 - seg_p0;
    end

    always_comb begin
        push_item         = '0;
        push_item.color_a = COLOR_WHITE;
        if (density <= pos[0]) begin
            push_item.color_a = color[0];
        end else if (density >= pos[last_slot]) begin
            push_item.color_a = color[last_slot];
        end else if (seg_found) begin
            push_item.color_a = seg_ca;
            if (seg_span != '0) begin
                push_item.interp  = 1'b1;
                push_item.color_b = seg_cb;
                push_item.num     = density - seg_p0;
                push_item.span    = seg_span;
            end
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

// ===== hw/rtl/msgcm_queue.sv =====
module msgcm_queue
    import msgcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  msgcm_item_t push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output msgcm_item_t pop_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    msgcm_item_t     mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != (AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + (AW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/msgcm_back.sv =====
module msgcm_back
    import msgcm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  msgcm_item_t            pop_item,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int QUO_W = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int ACC_W = CHAN_W + QUO_W;
    localparam logic [QUO_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]   rem_reg, rem_next;
    logic [POS_W-1:0]   span_reg, span_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [COLOR_W-1:0] ca_reg, ca_next;
    logic [COLOR_W-1:0] cb_reg, cb_next;
    logic [COLOR_W-1:0] out_reg, out_next;

    logic [POS_W:0]     trial;
    logic [POS_W:0]     diff;
    logic               ge;

    function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [QUO_W-1:0]  f);
        logic [QUO_W-1:0] inv;
        logic [ACC_W-1:0] acc;
        inv = FRAC_ONE - f;
        acc = ACC_W'(a) * ACC_W'(inv) + ACC_W'(b) * ACC_W'(f);
        return acc[FRAC_BITS +: CHAN_W];
    endfunction

    // restoring division, one quotient bit per cycle; the first step takes
    // the integer bit, which is one only at the segment end
    always_comb begin
        trial = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        diff  = trial - {1'b0, span_reg};
        ge    = (trial >= {1'b0, span_reg});
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        span_next  = span_reg;
        quo_next   = quo_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        out_next   = out_reg;
        pop_ready  = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    ca_next = pop_item.color_a;
                    cb_next = pop_item.color_b;
                    if (pop_item.interp) begin
                        rem_next   = pop_item.num;
                        span_next  = pop_item.span;
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = BK_DIV;
                    end else begin
                        out_next   = pop_item.color_a;
                        state_next = BK_HOLD;
                    end
                end
            end
            BK_DIV: begin
                rem_next = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS)) begin
                    state_next = BK_MIX;
                end
            end
            BK_MIX: begin
                out_next = {mix(ca_reg[23:16], cb_reg[23:16], quo_reg),
                            mix(ca_reg[15:8],  cb_reg[15:8],  quo_reg),
                            mix(ca_reg[7:0],   cb_reg[7:0],   quo_reg)};
                state_next = BK_HOLD;
            end
            BK_HOLD: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        span_reg <= span_next;
        quo_reg  <= quo_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        out_reg  <= out_next;
    end

    // red in the low byte, then green, then blue
    assign m_tdata = {out_reg[7:0], out_reg[15:8], out_reg[23:16]};

endmodule

// ===== verif/tb.sv =====
module tb;
    import msgcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDX_W        = $clog2(STOP_SLOTS_DEF + 1);
    localparam int          SLOT_W       = $clog2(STOP_SLOTS_DEF);
    localparam int          CFG_PAST_END = CFG_STOP_BASE + STOP_SLOTS_DEF;
    localparam logic [63:0] FRAC_ONE     = 64'd1 << FRAC_BITS_DEF;
    localparam int          SETTLE       = FRAC_BITS_DEF + 12;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 75;
    localparam int          DIRECTED_LEN = 33;
    localparam int          HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef enum bit {
        ROW_DENSITY,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [IDX_W-1:0]   index;
        logic [STOP_W-1:0]  value;
        logic [POS_W-1:0]   density;
        bit                 known;
        logic [COLOR_W-1:0] color;
    } plan_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [STOP_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [16:0] density
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [7:0] red, [15:8] green, [23:16] blue

    multi_stop_gradient_color_map dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shadow of the gradient registers
    logic [COUNT_W-1:0] stops_in_use;
    logic [STOP_W-1:0]  stop_regs [STOP_SLOTS_DEF];

    rgb_t pending_colors [$];
    int   mismatches     = 0;
    int   densities_sent = 0;
    int   colors_seen    = 0;
    int   stall_left     = 0;
    bit   stall_done     = 1'b0;
    logic calm;

    // a stretch with no random idles on either side
    assign calm = densities_sent >= 300 && densities_sent < 400;

    plan_row_t directed_plan [DIRECTED_LEN] = '{
        // default gradient: black at 0.0 to white at 1.0
        '{ROW_DENSITY, '0, '0, 17'h00000, 1'b1, 24'h000000},
        '{ROW_DENSITY, '0, '0, 17'h1FFFF, 1'b1, 24'hFFFFFF},
        '{ROW_DENSITY, '0, '0, 17'h10000, 1'b1, 24'hFFFFFF},
        '{ROW_DENSITY, '0, '0, 17'h08000, 1'b1, 24'h7F7F7F},
        '{ROW_DENSITY, '0, '0, 17'h00001, 1'b0, 24'h000000},
        '{ROW_DENSITY, '0, '0, 17'h0FFFF, 1'b0, 24'h000000},
        // four stops, middle two coincident
        '{ROW_WRITE, IDX_W'(CFG_STOP_COUNT), 41'd4, 17'h0, 1'b0, 24'h0},
        '{ROW_WRITE, IDX_W'(CFG_STOP_BASE + 0), {17'h04000, 24'h102030}, 17'h0, 1'b0, 24'h0},
        '{ROW_WRITE, IDX_W'(CFG_STOP_BASE + 1), {17'h08000, 24'hFF0000}, 17'h0, 1'b0, 24'h0},
        '{ROW_WRITE, IDX_W'(CFG_STOP_BASE + 2), {17'h08000, 24'h00FF00}, 17'h0, 1'b0, 24'h0},
        '{ROW_WRITE, IDX_W'(CFG_STOP_BASE + 3), {17'h1FFFF, 24'h0000FF}, 17'h0, 1'b0, 24'h0},
        '{ROW_DENSITY, '0, '0, 17'h00000, 1'b1, 24'h102030},
        '{ROW_DENSITY, '0, '0, 17'h04000, 1'b1, 24'h102030},
        '{ROW_DENSITY, '0, '0, 17'h1FFFF, 1'b1, 24'h0000FF},
        '{ROW_DENSITY, '0, '0, 17'h08000, 1'b0, 24'h000000},
        '{ROW_DENSITY, '0, '0, 17'h06000, 1'b0, 24'h000000},
        '{ROW_DENSITY, '0, '0, 17'h10000, 1'b0, 24'h000000},
        // zero count acts as a single stop
        '{ROW_WRITE, IDX_W'(CFG_STOP_COUNT), 41'd0, 17'h0, 1'b0, 24'h0},
        '{ROW_DENSITY, '0, '0, 17'h1FFFF, 1'b1, 24'h102030},
        '{ROW_DENSITY, '0, '0, 17'h00000, 1'b1, 24'h102030},
        // count above the slots acts as all slots
        '{ROW_WRITE, IDX_W'(CFG_STOP_COUNT), 41'd7, 17'h0, 1'b0, 24'h0},
        '{ROW_DENSITY, '0, '0, 17'h0C000, 1'b0, 24'h000000},
        '{ROW_WRITE, IDX_W'(CFG_STOP_BASE + 0), {STOP_W{1'b1}}, 17'h0, 1'b0, 24'h0},
        '{ROW_DENSITY, '0, '0, 17'h1FFFF, 1'b1, 24'hFFFFFF},
        '{ROW_DENSITY, '0, '0, 17'h05000, 1'b1, 24'hFFFFFF},
        // stops out of order
        '{ROW_WRITE, IDX_W'(CFG_STOP_COUNT), 41'd3, 17'h0, 1'b0, 24'h0},
        '{ROW_WRITE, IDX_W'(CFG_STOP_BASE + 0), {17'h08000, 24'h112233}, 17'h0, 1'b0, 24'h0},
        '{ROW_WRITE, IDX_W'(CFG_STOP_BASE + 1), {17'h02000, 24'h445566}, 17'h0, 1'b0, 24'h0},
        '{ROW_WRITE, IDX_W'(CFG_STOP_BASE + 2), {17'h0C000, 24'h778899}, 17'h0, 1'b0, 24'h0},
        '{ROW_DENSITY, '0, '0, 17'h09000, 1'b0, 24'h000000},
        '{ROW_DENSITY, '0, '0, 17'h02000, 1'b1, 24'h112233},
        // index past the register list must not land anywhere
        '{ROW_WRITE, IDX_W'(CFG_PAST_END), {STOP_W{1'b1}}, 17'h0, 1'b0, 24'h0},
        '{ROW_DENSITY, '0, '0, 17'h0A000, 1'b0, 24'h000000}
    };

    function automatic rgb_t to_rgb(logic [COLOR_W-1:0] c);
        return '{blue: c[7:0], green: c[15:8], red: c[23:16]};
    endfunction

    function automatic logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] a,
                                                      logic [CHAN_W-1:0] b,
                                                      logic [63:0] frac);
        logic [63:0] sum;
        sum = 64'(a) * (FRAC_ONE - frac) + 64'(b) * frac;
        return sum[FRAC_BITS_DEF +: CHAN_W];
    endfunction

    function automatic rgb_t color_for(logic [POS_W-1:0] d);
        int                 last;
        logic [63:0]        p0;
        logic [63:0]        p1;
        logic [63:0]        frac;
        logic [COLOR_W-1:0] ca;
        logic [COLOR_W-1:0] cb;
        rgb_t               c;
        if (stops_in_use == 0) begin
            last = 0;
        end else if (stops_in_use > STOP_SLOTS_DEF) begin
            last = STOP_SLOTS_DEF - 1;
        end else begin
            last = int'(stops_in_use) - 1;
        end
        if (d <= stop_regs[0][STOP_W-1 -: POS_W])
            return to_rgb(stop_regs[0][COLOR_W-1:0]);
        if (d >= stop_regs[last][STOP_W-1 -: POS_W])
            return to_rgb(stop_regs[last][COLOR_W-1:0]);
        for (int i = 0; i < last; i++) begin
            p0 = 64'(stop_regs[i][STOP_W-1 -: POS_W]);
            p1 = 64'(stop_regs[i+1][STOP_W-1 -: POS_W]);
            if (64'(d) >= p0 && 64'(d) <= p1) begin
                ca = stop_regs[i][COLOR_W-1:0];
                if (p1 == p0)
                    return to_rgb(ca);
                cb = stop_regs[i+1][COLOR_W-1:0];
                frac = ((64'(d) - p0) << FRAC_BITS_DEF) / (p1 - p0);
                c.red   = mix_channel(ca[23:16], cb[23:16], frac);
                c.green = mix_channel(ca[15:8], cb[15:8], frac);
                c.blue  = mix_channel(ca[7:0], cb[7:0], frac);
                return c;
            end
        end
        return to_rgb(COLOR_WHITE);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [STOP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        if (idx == CFG_STOP_COUNT)
            stops_in_use = value[COUNT_W-1:0];
        else if (idx < CFG_PAST_END)
            stop_regs[SLOT_W'(idx - IDX_W'(CFG_STOP_BASE))] = value;
    endtask

    task automatic send_density(logic [POS_W-1:0] d, bit known, logic [COLOR_W-1:0] color);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(d);
        do @(posedge aclk); while (!s_tready);
        pending_colors.insert(pending_colors.size(), known ? to_rgb(color) : color_for(d));
        densities_sent++;
        while (!calm && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls, one long hold, compare against the oldest expectation
    always @(posedge aclk) begin
        rgb_t got;
        rgb_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = rgb_t'(m_tdata);
            colors_seen++;
            if (pending_colors.size() == 0) begin
                report_mismatch("color with no request", int'(m_tdata), 0);
            end else begin
                want = pending_colors.pop_front();
                if (got.red != want.red)
                    report_mismatch("red", int'(got.red), int'(want.red));
                if (got.green != want.green)
                    report_mismatch("green", int'(got.green), int'(want.green));
                if (got.blue != want.blue)
                    report_mismatch("blue", int'(got.blue), int'(want.blue));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!stall_done && colors_seen == 100) begin
            stall_done = 1'b1;
            stall_left = HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 23);
        end
    end

    initial begin
        bit                 writing;
        int                 pick;
        int                 positions [$];
        logic [COUNT_W-1:0] count;
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   d;

        stops_in_use = COUNT_RESET;
        foreach (stop_regs[i])
            stop_regs[i] = STOP_RESET_ANY;
        stop_regs[1] = STOP_RESET_ONE;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        writing = 1'b0;
        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_WRITE) begin
                if (!writing) begin
                    wait_until_idle();
                    writing = 1'b1;
                end
                write_reg(directed_plan[r].index, directed_plan[r].value);
            end else begin
                if (writing) begin
                    cfg_we  <= 1'b0;
                    writing = 1'b0;
                end
                send_density(directed_plan[r].density, directed_plan[r].known,
                             directed_plan[r].color);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_until_idle();
            if ($urandom_range(99) < 80)
                count = COUNT_W'($urandom_range(1, STOP_SLOTS_DEF));
            else
                count = COUNT_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 7));
            positions.delete();
            for (int s = 0; s < STOP_SLOTS_DEF; s++) begin
                pick = $urandom_range(99);
                if (s > 0 && pick < 10)
                    positions.insert(positions.size(), positions[s-1]);
                else if (pick < 25)
                    case ($urandom_range(0, 2))
                        0:       positions.insert(positions.size(), 0);
                        1:       positions.insert(positions.size(), 32'h10000);
                        default: positions.insert(positions.size(), 32'h1FFFF);
                    endcase
                else
                    positions.insert(positions.size(), $urandom_range(0, 32'h1FFFF));
            end
            // mostly ordered gradients, some scrambled
            if ($urandom_range(0, 3) != 0)
                positions.sort();

            write_reg(IDX_W'(CFG_STOP_COUNT), STOP_W'(count));
            for (int s = 0; s < STOP_SLOTS_DEF; s++) begin
                color = '0;
                for (int ch = 0; ch < 3; ch++) begin
                    pick  = $urandom_range(99);
                    color = {color[15:0],
                             (pick < 15) ? 8'h00 : (pick < 30) ? 8'hFF
                                         : 8'($urandom_range(0, 255))};
                end
                write_reg(IDX_W'(CFG_STOP_BASE + s), {POS_W'(positions[s]), color});
            end
            if (phase % 2 == 1)
                write_reg(IDX_W'(CFG_PAST_END + $urandom_range(0, 2)),
                          STOP_W'({$urandom, $urandom}));
            cfg_we <= 1'b0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 40)
                    d = POS_W'($urandom_range(0, 32'h1FFFF));
                else if (pick < 75)
                    d = POS_W'(positions[$urandom_range(0, STOP_SLOTS_DEF - 1)]
                               + int'($urandom_range(0, 6)) - 3);
                else if (pick < 90)
                    d = POS_W'($urandom_range(positions[0], positions[STOP_SLOTS_DEF - 1]));
                else
                    case ($urandom_range(0, 2))
                        0:       d = '0;
                        1:       d = 17'h10000;
                        default: d = '1;
                    endcase
                send_density(d, 1'b0, '0);
            end
        end

        wait_until_idle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
